/* rtl/core/lpe_pkg.sv */
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared types, widths and reset values for the line position estimator.
// ----------------------------------------------------------------------------
package lpe_pkg;

	localparam int WINDOW      = 8;
	localparam int SAMPLE_BITS = 12;
	localparam int SLOT_BITS   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_BITS    = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
	localparam int TOTAL_BITS  = SUM_BITS + 1;

	localparam int DETECT_BITS = 15;
	localparam int MIN_BITS    = 16;
	localparam int SLOPE_BITS  = 16;
	localparam int OFFSET_BITS = 12;
	localparam int VALUE_BITS  = 15;
	localparam int SCALE_SHIFT = 16;
	localparam int PROD_BITS   = TOTAL_BITS + SLOPE_BITS;
	localparam int SCALED_BITS = PROD_BITS - SCALE_SHIFT;
	localparam int MAG_BITS    = ((SCALED_BITS > OFFSET_BITS) ? SCALED_BITS : OFFSET_BITS) + 1;
	localparam int POS_BITS    = 16;

	localparam int ITEM_BITS      = 2 * SAMPLE_BITS + 4;
	localparam int IN_TDATA_BITS  = ((ITEM_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = POS_BITS;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [DETECT_BITS-1:0] DETECT_RESET = DETECT_BITS'(27797);
	localparam logic [MIN_BITS-1:0]    MIN_RESET    = MIN_BITS'(12449);
	localparam logic [SLOPE_BITS-1:0]  SLOPE_RESET  = SLOPE_BITS'(3909);
	localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(588);
	localparam logic [VALUE_BITS-1:0]  OUTER_RESET  = VALUE_BITS'(13312);
	localparam logic [VALUE_BITS-1:0]  INNER_RESET  = VALUE_BITS'(6912);

	localparam logic [31:0] POS_MAX_MAG = 32'd32767;
	localparam logic signed [POS_BITS-1:0] POS_MAX = 16'sh7fff;
	localparam logic signed [POS_BITS-1:0] POS_MIN = 16'sh8000;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DETECT_LIMIT = 3'd0,
		REG_MIN_TOTAL    = 3'd1,
		REG_SLOPE_COEF   = 3'd2,
		REG_OFFSET_Q8    = 3'd3,
		REG_OUTER_VALUE  = 3'd4,
		REG_INNER_VALUE  = 3'd5
	} cfg_reg_t;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_BITS-1:0] sum_t;
	typedef logic [TOTAL_BITS-1:0] total_t;
	typedef logic signed [POS_BITS-1:0] pos_t;

	typedef struct packed {
		logic [DETECT_BITS-1:0] detect_limit;
		logic [MIN_BITS-1:0]    min_total;
		logic [SLOPE_BITS-1:0]  slope_coef;
		logic [OFFSET_BITS-1:0] offset_q8;
		logic [VALUE_BITS-1:0]  outer_value;
		logic [VALUE_BITS-1:0]  inner_value;
	} cfg_t;

	// first member lands in the top bits, so left_sample sits lowest
	typedef struct packed {
		logic    rightmost_bit;
		logic    right_inner_bit;
		logic    left_inner_bit;
		logic    leftmost_bit;
		sample_t right_sample;
		sample_t left_sample;
	} item_t;

	typedef struct packed {
		sum_t left_sum;
		sum_t right_sum;
		logic leftmost_seen;
		logic left_inner_seen;
		logic right_inner_seen;
		logic rightmost_seen;
	} sums_t;

	typedef struct packed {
		logic   analog;
		logic   use_mag;
		logic   negative;
		total_t total;
		pos_t   digital_pos;
	} decision_t;

endpackage

/* rtl/core/lpe_window.sv */
// ----------------------------------------------------------------------------
// lpe_window
// Sample rings and running window sums for both analog channels.
// ----------------------------------------------------------------------------
module lpe_window (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  lpe_pkg::item_t item,
	output lpe_pkg::sums_t sums
);
	import lpe_pkg::*;

	sample_t left_ring_q [WINDOW];
	sample_t right_ring_q [WINDOW];
	sum_t left_sum_q;
	sum_t right_sum_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [3:0] seen_q;

	sum_t left_sum_d;
	sum_t right_sum_d;
	logic [SLOT_BITS-1:0] slot_d;

	always_comb begin
		left_sum_d  = left_sum_q - SUM_BITS'(left_ring_q[slot_q]) + SUM_BITS'(item.left_sample);
		right_sum_d = right_sum_q - SUM_BITS'(right_ring_q[slot_q])
			+ SUM_BITS'(item.right_sample);
		if (slot_q == SLOT_BITS'(WINDOW - 1)) begin
			slot_d = '0;
		end else begin
			slot_d = slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW; i++) begin
				left_ring_q[i]  <= '0;
				right_ring_q[i] <= '0;
			end
			left_sum_q  <= '0;
			right_sum_q <= '0;
			slot_q      <= '0;
		end else if (advance) begin
			left_ring_q[slot_q]  <= item.left_sample;
			right_ring_q[slot_q] <= item.right_sample;
			left_sum_q  <= left_sum_d;
			right_sum_q <= right_sum_d;
			slot_q      <= slot_d;
		end
	end

	// sensors are active low
	always_ff @(posedge clk) begin
		if (advance) begin
			seen_q <= {~item.leftmost_bit, ~item.left_inner_bit,
				~item.right_inner_bit, ~item.rightmost_bit};
		end
	end

	assign sums.left_sum         = left_sum_q;
	assign sums.right_sum        = right_sum_q;
	assign sums.leftmost_seen    = seen_q[3];
	assign sums.left_inner_seen  = seen_q[2];
	assign sums.right_inner_seen = seen_q[1];
	assign sums.rightmost_seen   = seen_q[0];

endmodule

/* rtl/core/lpe_decide.sv */
// ----------------------------------------------------------------------------
// lpe_decide
// Picks analog or digital mode and the digital position from the window sums.
// ----------------------------------------------------------------------------
module lpe_decide (
	input  logic              clk,
	input  logic              advance,
	input  lpe_pkg::cfg_t      cfg,
	input  lpe_pkg::sums_t     sums,
	output lpe_pkg::decision_t decision
);
	import lpe_pkg::*;

	decision_t dec_d;
	decision_t dec_s3;
	pos_t outer_pos;
	pos_t inner_pos;

	always_comb begin
		outer_pos = pos_t'(cfg.outer_value);
		inner_pos = pos_t'(cfg.inner_value);
		dec_d.analog = (32'(sums.left_sum) < 32'(cfg.detect_limit))
			|| (32'(sums.right_sum) < 32'(cfg.detect_limit));
		dec_d.total = TOTAL_BITS'(sums.left_sum) + TOTAL_BITS'(sums.right_sum);
		dec_d.use_mag = dec_d.analog && (32'(dec_d.total) >= 32'(cfg.min_total));
		// equal sums take the negative sign, like a line on the right sensors
		dec_d.negative = !(sums.right_sum > sums.left_sum);
		if (sums.leftmost_seen) begin
			dec_d.digital_pos = outer_pos;
		end else if (sums.left_inner_seen) begin
			dec_d.digital_pos = inner_pos;
		end else if (sums.right_inner_seen) begin
			dec_d.digital_pos = -inner_pos;
		end else if (sums.rightmost_seen) begin
			dec_d.digital_pos = -outer_pos;
		end else begin
			dec_d.digital_pos = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dec_s3 <= dec_d;
		end
	end

	assign decision = dec_s3;

endmodule

/* rtl/core/lpe_scale.sv */
// ----------------------------------------------------------------------------
// lpe_scale
// Scales the analog total, applies sign and saturation, picks and holds the result word.
// ----------------------------------------------------------------------------
module lpe_scale (
	input  logic              clk,
	input  logic              advance,
	input  lpe_pkg::cfg_t      cfg,
	input  lpe_pkg::decision_t decision,
	output lpe_pkg::pos_t      position,
	output logic              analog_mode
);
	import lpe_pkg::*;

	logic [PROD_BITS-1:0] product;
	logic [MAG_BITS-1:0] mag;
	logic [31:0] mag_ext;
	pos_t analog_pos;
	pos_t pos_d;
	pos_t position_q;
	logic analog_q;

	always_comb begin
		product = PROD_BITS'(decision.total) * PROD_BITS'(cfg.slope_coef);
		mag = MAG_BITS'(product[PROD_BITS-1:SCALE_SHIFT]) + MAG_BITS'(cfg.offset_q8);
		mag_ext = 32'(mag);
		if (!decision.negative) begin
			analog_pos = (mag_ext > POS_MAX_MAG) ? POS_MAX : pos_t'(mag_ext[POS_BITS-1:0]);
		end else begin
			analog_pos = (mag_ext > POS_MAX_MAG) ? POS_MIN : -pos_t'(mag_ext[POS_BITS-1:0]);
		end
		if (decision.use_mag) begin
			pos_d = analog_pos;
		end else if (decision.analog) begin
			pos_d = '0;
		end else begin
			pos_d = decision.digital_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			position_q <= pos_d;
			analog_q   <= decision.analog;
		end
	end

	assign position    = position_q;
	assign analog_mode = analog_q;

endmodule

/* rtl/core/line_position_estimator.sv */
// ----------------------------------------------------------------------------
// line_position_estimator
// An accepted word passes item_s1, the window sums, dec_s3 and position_q.
// Throughput: one word per cycle; stages only stall when the result is held.
// Reset clears the sample rings, window sums and ring slot, loads the default
// register values and empties the pipeline.
// ----------------------------------------------------------------------------
module line_position_estimator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// left_sample[11:0], right_sample[23:12], leftmost_bit[24], left_inner_bit[25],
	// right_inner_bit[26], rightmost_bit[27], zero fill
	input  logic [lpe_pkg::IN_TDATA_BITS-1:0]     s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// position[15:0]
	output logic [lpe_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
	// analog_mode[0]
	output logic                                  m_tuser,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lpe_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [lpe_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import lpe_pkg::*;

	cfg_t cfg_q;
	item_t item_s1;
	logic valid_s1_q;
	logic valid_s2_q;
	logic valid_s3_q;
	logic valid_out_q;
	logic out_en;
	logic s3_en;
	logic s2_en;
	logic s1_en;
	sums_t sums;
	decision_t decision;
	pos_t position;
	logic analog_mode;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.detect_limit <= DETECT_RESET;
			cfg_q.min_total    <= MIN_RESET;
			cfg_q.slope_coef   <= SLOPE_RESET;
			cfg_q.offset_q8    <= OFFSET_RESET;
			cfg_q.outer_value  <= OUTER_RESET;
			cfg_q.inner_value  <= INNER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DETECT_LIMIT: cfg_q.detect_limit <= cfg_data[DETECT_BITS-1:0];
				REG_MIN_TOTAL:    cfg_q.min_total    <= cfg_data[MIN_BITS-1:0];
				REG_SLOPE_COEF:   cfg_q.slope_coef   <= cfg_data[SLOPE_BITS-1:0];
				REG_OFFSET_Q8:    cfg_q.offset_q8    <= cfg_data[OFFSET_BITS-1:0];
				REG_OUTER_VALUE:  cfg_q.outer_value  <= cfg_data[VALUE_BITS-1:0];
				REG_INNER_VALUE:  cfg_q.inner_value  <= cfg_data[VALUE_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// each stage moves when the one after it is empty or moving
	assign out_en   = !valid_out_q || m_tready;
	assign s3_en    = !valid_s3_q || out_en;
	assign s2_en    = !valid_s2_q || s3_en;
	assign s1_en    = !valid_s1_q || s2_en;
	assign s_tready = s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q  <= 1'b0;
			valid_s2_q  <= 1'b0;
			valid_s3_q  <= 1'b0;
			valid_out_q <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1_q <= s_tvalid;
			end
			if (s2_en) begin
				valid_s2_q <= valid_s1_q;
			end
			if (s3_en) begin
				valid_s3_q <= valid_s2_q;
			end
			if (out_en) begin
				valid_out_q <= valid_s3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s1_en) begin
			item_s1 <= item_t'(s_tdata[ITEM_BITS-1:0]);
		end
	end

	lpe_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (valid_s1_q && s2_en),
		.item    (item_s1),
		.sums    (sums)
	);

	lpe_decide u_decide (
		.clk      (clk),
		.advance  (valid_s2_q && s3_en),
		.cfg      (cfg_q),
		.sums     (sums),
		.decision (decision)
	);

	lpe_scale u_scale (
		.clk         (clk),
		.advance     (valid_s3_q && out_en),
		.cfg         (cfg_q),
		.decision    (decision),
		.position    (position),
		.analog_mode (analog_mode)
	);

	assign m_tvalid = valid_out_q;
	assign m_tdata  = OUT_TDATA_BITS'(position);
	assign m_tuser  = analog_mode;

endmodule
